>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i once reset has been released.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/stok_pkg.sv
`default_nettype none

package stok_pkg;

  localparam int unsigned OUT_POS_W  = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef enum logic [3:0] {
    TK_END       = 4'd0,
    TK_IDENT     = 4'd1,
    TK_PRINT     = 4'd2,
    TK_NUMBER    = 4'd3,
    TK_PLUS      = 4'd4,
    TK_MINUS     = 4'd5,
    TK_MUL       = 4'd6,
    TK_DIV       = 4'd7,
    TK_ASSIGN    = 4'd8,
    TK_LPAREN    = 4'd9,
    TK_RPAREN    = 4'd10,
    TK_SEMICOLON = 4'd11,
    TK_UNKNOWN   = 4'd12
  } tok_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } scan_mode_e;

  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_END  = 1'b1;

  localparam logic [2:0] KW_LEN  = 3'd5;
  localparam logic [2:0] KW_NONE = 3'd7;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_P          = 8'h70;

  typedef struct packed {
    tok_kind_e              tok_kind;
    logic [OUT_POS_W-1:0]   start_pos;
    logic [OUT_POS_W-1:0]   token_len;
    logic [7:0]             first_byte;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } lex_out_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'h09:8'h0D], 8'h20};
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h70;
      3'd1: ch = 8'h72;
      3'd2: ch = 8'h69;
      3'd3: ch = 8'h6E;
      3'd4: ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic tok_kind_e single_kind(input logic [7:0] c);
    tok_kind_e k;
    case (c)
      8'h2B: k = TK_PLUS;
      8'h2D: k = TK_MINUS;
      8'h2A: k = TK_MUL;
      8'h2F: k = TK_DIV;
      8'h3D: k = TK_ASSIGN;
      8'h28: k = TK_LPAREN;
      8'h29: k = TK_RPAREN;
      8'h3B: k = TK_SEMICOLON;
      default: k = TK_END;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> sv/stok_lexer.sv
`default_nettype none
`include "assert_macros.svh"

module stok_lexer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  logic               in_kind_i,
  input  logic [7:0]         in_byte_i,
  output stok_pkg::lex_out_t lex_o
);
  import stok_pkg::*;

  localparam logic [POSITION_BITS-1:0] LenMax = '1;

  scan_mode_e               mode_q, mode_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] len_q, len_d;
  logic [2:0]               kw_q, kw_d;
  logic [7:0]               first_q, first_d;
  logic                     ended_q, ended_d;

  logic [POSITION_BITS+OUT_POS_W-1:0] pos_ext, start_ext, len_ext;
  logic [OUT_POS_W-1:0]               pos16, start16, len16;
  logic                               pending, flush_v, sec_v;
  res_t                               flush_r, sec_r;
  tok_kind_e                          single;
  logic [7:0]                         c;

  assign c         = in_byte_i;
  assign pos_ext   = {{OUT_POS_W{1'b0}}, pos_q};
  assign start_ext = {{OUT_POS_W{1'b0}}, start_q};
  assign len_ext   = {{OUT_POS_W{1'b0}}, len_q};
  assign pos16     = pos_ext[OUT_POS_W-1:0];
  assign start16   = start_ext[OUT_POS_W-1:0];
  assign len16     = len_ext[OUT_POS_W-1:0];
  assign pending   = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
  assign single    = single_kind(c);

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    pos_d   = pos_q;
    len_d   = len_q;
    kw_d    = kw_q;
    first_d = first_q;
    ended_d = ended_q;
    flush_v = 1'b0;
    sec_v   = 1'b0;

    flush_r.tok_kind   = (mode_q == MODE_NUMBER) ? TK_NUMBER :
                         ((kw_q == KW_LEN) ? TK_PRINT : TK_IDENT);
    flush_r.start_pos  = start16;
    flush_r.token_len  = len16;
    flush_r.first_byte = first_q;
    flush_r.last       = 1'b0;

    sec_r.tok_kind   = TK_END;
    sec_r.start_pos  = pos16;
    sec_r.token_len  = '0;
    sec_r.first_byte = '0;
    sec_r.last       = 1'b1;

    if (ended_q) begin
      sec_v = 1'b1;
    end else if (in_kind_i == IN_END || c == CH_NUL) begin
      flush_v = pending;
      sec_v   = 1'b1;
      mode_d  = MODE_IDLE;
      kw_d    = '0;
      len_d   = '0;
      ended_d = 1'b1;
    end else begin
      if ((mode_q == MODE_IDENT && (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE)) ||
          (mode_q == MODE_NUMBER && is_digit(c))) begin
        if (len_q < LenMax) begin
          len_d = len_q + POSITION_BITS'(1);
        end
        if (mode_q == MODE_IDENT) begin
          if (kw_q < KW_LEN && c == kw_char(kw_q)) begin
            kw_d = kw_q + 3'd1;
          end else begin
            kw_d = KW_NONE;
          end
        end
      end else begin
        flush_v = pending;
        mode_d  = MODE_IDLE;
        kw_d    = '0;
        len_d   = '0;
        if (is_space(c)) begin
          mode_d = MODE_IDLE;
        end else if (single != TK_END) begin
          sec_v            = 1'b1;
          sec_r.tok_kind   = single;
          sec_r.token_len  = OUT_POS_W'(1);
          sec_r.first_byte = c;
        end else if (is_alpha(c) || is_digit(c)) begin
          mode_d  = is_alpha(c) ? MODE_IDENT : MODE_NUMBER;
          start_d = pos_q;
          len_d   = POSITION_BITS'(1);
          first_d = c;
          kw_d    = (is_alpha(c) && c == CH_P) ? 3'd1 : KW_NONE;
        end else begin
          sec_v            = 1'b1;
          sec_r.tok_kind   = TK_UNKNOWN;
          sec_r.token_len  = OUT_POS_W'(1);
          sec_r.first_byte = c;
        end
      end
      pos_d = pos_q + POSITION_BITS'(1);
    end

    lex_o.r1 = sec_r;
    if (flush_v) begin
      lex_o.r0      = flush_r;
      lex_o.r0.last = !sec_v;
      lex_o.n       = sec_v ? 2'd2 : 2'd1;
    end else begin
      lex_o.r0 = sec_r;
      lex_o.n  = sec_v ? 2'd1 : 2'd0;
    end
    if (!step_en_i) begin
      lex_o.n = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      kw_q    <= '0;
      first_q <= '0;
      ended_q <= 1'b0;
    end else if (step_en_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      kw_q    <= kw_d;
      first_q <= first_d;
      ended_q <= ended_d;
    end
  end

  `ASSERT_CLK(a_ended_freezes, ended_q |=> ended_q && $stable(pos_q) && mode_q == MODE_IDLE,
              "Position or scan mode moved after end of input.")
  `ASSERT_CLK(a_pending_len, pending |-> len_q != '0,
              "A pending token has zero length.")

endmodule

`default_nettype wire

>>> sv/stok_result_fifo.sv
`default_nettype none
`include "assert_macros.svh"

module stok_result_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stok_pkg::lex_out_t push_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output stok_pkg::res_t     out_word_o,
  output logic               room_o
);
  import stok_pkg::*;

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + FIFO_PTR_W'(push_i.n);
    rd_d  = rd_q + FIFO_PTR_W'(pop);
    cnt_d = cnt_q + FIFO_CNT_W'(push_i.n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + FIFO_PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_CLK(a_no_overflow, push_i.n != 2'd0 |-> cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2),
              "Results pushed without room for two words.")
  `ASSERT_ALWAYS(a_count_range, !rst_ni || cnt_q <= FIFO_CNT_W'(FIFO_DEPTH),
                 "Result queue count beyond its depth.")

endmodule

`default_nettype wire

>>> sv/source_tokenizer.sv
`default_nettype none

// Source tokenizer: takes one source byte per word on the input channel and
// delivers tokens (kind, start position, length, first byte) on the output
// channel, with last marking the final token caused by an input word. A byte
// is taken every cycle unless the input stalls; it is registered, classified
// combinationally against the scan state, and its zero, one or two tokens are
// written to a four-word result queue. The queue pops one token per cycle
// unless the output stalls, and the input stalls only while the queue holds
// more than two words. The end-of-input word or a zero byte flushes any pending
// token and ends the stream; every later word gives one end token.

module source_tokenizer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] start_pos_o,
  output logic [15:0] token_len_o,
  output logic [7:0]  first_byte_o,
  output logic        last_o
);
  import stok_pkg::*;

  logic       in_vld_q;
  logic       in_kind_q;
  logic [7:0] in_byte_q;
  logic       step_en;
  logic       room;
  logic       accept;
  lex_out_t   lex;
  res_t       out_word;

  assign step_en    = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (step_en) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_kind_q <= kind_i;
      in_byte_q <= byte_in_i;
    end
  end

  stok_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .in_kind_i (in_kind_q),
    .in_byte_i (in_byte_q),
    .lex_o     (lex)
  );

  stok_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (lex),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word),
    .room_o      (room)
  );

  assign token_kind_o = out_word.tok_kind;
  assign start_pos_o  = out_word.start_pos;
  assign token_len_o  = out_word.token_len;
  assign first_byte_o = out_word.first_byte;
  assign last_o       = out_word.last;

endmodule

`default_nettype wire
